>>> hw/rtl/wto_pkg.sv
// Shared types and constants for the wavetable oscillator.
`timescale 1ns / 1ps

package wto_pkg;

  // Fixed field and register widths of the stream and configuration ports.
  localparam int unsigned TABLE_INDEX_W = 12;
  localparam int unsigned TABLE_WORD_W  = 16;
  localparam int unsigned FREQ_W        = 32;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned IN_TDATA_W    = 64;
  localparam int unsigned OUT_TDATA_W   = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CFG_LEN_W     = 13;
  localparam int unsigned START_PHASE_W = 16;

  // Register values after reset.
  localparam int unsigned TABLE_LENGTH_RST     = 4096;
  localparam logic [31:0] LENGTH_OVER_RATE_RST = 32'd1431656;
  localparam logic        INTERPOLATE_RST      = 1'b1;

  // Bit position of the fixed-point product that lines up with the phase LSB.
  localparam int unsigned INCR_ALIGN = 40;

  // Kind of an input beat, carried on tuser.
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } act_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_LENGTH     = 2'd0,
    CFG_LENGTH_OVER_RATE = 2'd1,
    CFG_INTERPOLATE      = 2'd2,
    CFG_START_PHASE      = 2'd3
  } cfg_reg_e;

  // Commands to the phase reduction unit.
  typedef struct packed {
    logic start;
    logic abort;
  } mod_ctl_t;

endpackage

>>> hw/rtl/wto_phase_mod.sv
// Iterative remainder unit that folds the phase index into a new table length.
`timescale 1ns / 1ps

module wto_phase_mod #(
  parameter int unsigned AW = 12,
  parameter int unsigned LW = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wto_pkg::mod_ctl_t ctl_i,
  input  logic [LW-1:0]     len_i,
  input  logic [AW-1:0]     idx_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [AW-1:0]     rem_o
);

  localparam int unsigned SW = (AW > 1) ? $clog2(AW) : 1;
  localparam int unsigned WW = AW + LW;

  logic          busy_q, busy_d;
  logic [SW-1:0] step_q, step_d;
  logic [AW-1:0] rem_q, rem_d, rem_step;
  logic [LW-1:0] len_q, len_d;
  logic [WW-1:0] cand;
  logic [WW-1:0] rem_ext;
  logic [WW-1:0] rem_sub;

  // One restoring step: subtract the length shifted to the current bit if it fits.
  always_comb begin
    rem_ext  = {{LW{1'b0}}, rem_q};
    cand     = {{AW{1'b0}}, len_q} << step_q;
    rem_sub  = rem_ext - cand;
    rem_step = (rem_ext >= cand) ? rem_sub[AW-1:0] : rem_q;
  end

  assign done_o = busy_q && (step_q == '0);
  assign busy_o = busy_q;
  assign rem_o  = rem_step;

  // Sequencer: load on start, stop on abort, walk the bit positions down to zero.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    len_d  = len_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      step_d = SW'(AW - 1);
      rem_d  = idx_i;
      len_d  = len_i;
    end else if (ctl_i.abort) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      rem_d = rem_step;
      if (step_q == '0) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q - SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    len_q <= len_d;
  end

  // The finished remainder is always below the length it was reduced by.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ctl_i.start && !ctl_i.abort |-> ({{LW{1'b0}}, rem_o} < {{AW{1'b0}}, len_q}))
    else $error("phase remainder not below table length");

  // A finished reduction leaves the unit idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ctl_i.start |=> !busy_q)
    else $error("reduction unit still busy after its last step");

  // A start always makes the unit busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> busy_q)
    else $error("reduction unit did not start");

endmodule

>>> hw/rtl/wavetable_oscillator.sv
// Top level of the wavetable oscillator: table store, phase accumulator, interpolator.
`timescale 1ns / 1ps
// A tick beat passes the stage registers A to E and the output register on its way to m_axis.
// Throughput: one input beat per cycle, table writes and ticks alike, set by the stage pipeline,
// while m_axis takes every sample. A table_length write runs a bit-serial remainder over the
// phase index; s_axis_tready stays low meanwhile.
// Reset clears the pipeline, the phase and the registers; the table contents stay undefined.

module wavetable_oscillator #(
  parameter int unsigned TABLE_DEPTH     = 4096,
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned PHASE_FRAC_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [11:0] table_index, [27:12] table_word, [59:28] freq, [63:60] zero
  input  logic [wto_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // [0] action
  input  logic                                  s_axis_tuser,
  // Output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [15:0] sample
  output logic [wto_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [wto_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [wto_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned F   = PHASE_FRAC_BITS;
  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned LW  = AW + 1;
  localparam int unsigned PHW = AW + F;
  localparam int unsigned SPW = LW + F;
  localparam int unsigned XW  = (LW > wto_pkg::CFG_LEN_W) ? LW : wto_pkg::CFG_LEN_W;
  localparam int unsigned SH  = wto_pkg::INCR_ALIGN - F;
  localparam int unsigned PW  = SB + F + 2;
  localparam int unsigned LEN_RST = (wto_pkg::TABLE_LENGTH_RST > TABLE_DEPTH) ?
                                    TABLE_DEPTH : wto_pkg::TABLE_LENGTH_RST;

  // Configuration and phase state
  logic [LW-1:0]  len_q, len_d;
  logic [31:0]    lor_q;
  logic           interp_q;
  logic [PHW-1:0] phase_q, phase_d;
  logic [SPW-1:0] span;

  // Pipeline valids and flow control
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, o_vld_q;
  logic free_a, free_b, free_c, free_d, free_e, free_o;
  logic s_fire, c_tick_fire, c_write_fire;

  // Stage payloads
  logic                              a_tick_q;
  logic [wto_pkg::TABLE_INDEX_W-1:0] a_index_q;
  logic [wto_pkg::TABLE_WORD_W-1:0]  a_word_q;
  logic [wto_pkg::FREQ_W-1:0]        a_freq_q;
  logic                              b_tick_q;
  logic [wto_pkg::TABLE_INDEX_W-1:0] b_index_q;
  logic [wto_pkg::TABLE_WORD_W-1:0]  b_word_q;
  logic                              b_neg_q;
  logic [63:0]                       b_prod_q;
  logic                              c_tick_q;
  logic [wto_pkg::TABLE_INDEX_W-1:0] c_index_q;
  logic [wto_pkg::TABLE_WORD_W-1:0]  c_word_q;
  logic                              c_neg_q;
  logic [PHW-1:0]                    c_mag_q;
  logic [SB-1:0]                     d_a_q, d_b_q;
  logic [F-1:0]                      d_frac_q;
  logic [SB-1:0]                     e_a_q;
  logic signed [PW-1:0]              e_prod_q;
  logic [SB-1:0]                     o_sample_q;

  // Table store
  logic [SB-1:0] mem_q [TABLE_DEPTH];

  // Reduction unit hookup
  wto_pkg::mod_ctl_t mod_ctl;
  logic              mod_busy, mod_done;
  logic [AW-1:0]     mod_rem;

  assign span = {len_q, {F{1'b0}}};

  // Ready chain: a stage is free when empty or when its content moves on.
  assign free_o = !o_vld_q || m_axis_tready;
  assign free_e = !e_vld_q || free_o;
  assign free_d = !d_vld_q || free_e;
  assign free_c = !c_vld_q || !c_tick_q || free_d;
  assign free_b = !b_vld_q || free_c;
  assign free_a = !a_vld_q || free_b;

  assign s_axis_tready = free_a && !mod_busy;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign c_tick_fire   = c_vld_q && c_tick_q && free_d;
  assign c_write_fire  = c_vld_q && !c_tick_q;

  assign m_axis_tvalid = o_vld_q;

  // Output sample, truncated or zero-filled to the field width.
  logic [SB+wto_pkg::SAMPLE_W-1:0] out_wide;
  assign out_wide     = {{wto_pkg::SAMPLE_W{1'b0}}, o_sample_q};
  assign m_axis_tdata = out_wide[wto_pkg::SAMPLE_W-1:0];

  // ---------------------------------------------------------------------
  // Configuration decode
  // ---------------------------------------------------------------------
  logic                                 cfg_len_we, cfg_start_we;
  logic [XW-1:0]                        len_req;
  logic [wto_pkg::START_PHASE_W+LW-1:0] start_prod;
  logic [wto_pkg::START_PHASE_W+F-1:0]  start_frac_w;
  logic [PHW-1:0]                       start_phase;

  assign cfg_len_we   = cfg_we_i && (cfg_index_i == wto_pkg::CFG_TABLE_LENGTH);
  assign cfg_start_we = cfg_we_i && (cfg_index_i == wto_pkg::CFG_START_PHASE);

  // Clamp a requested length into [2, TABLE_DEPTH].
  always_comb begin
    len_req = XW'(cfg_data_i[wto_pkg::CFG_LEN_W-1:0]);
    if (len_req < XW'(2)) begin
      len_d = LW'(2);
    end else if (len_req > XW'(TABLE_DEPTH)) begin
      len_d = LW'(TABLE_DEPTH);
    end else begin
      len_d = len_req[LW-1:0];
    end
  end

  // Start phase: the 0.16 fraction of a cycle scaled by the length in entries.
  assign start_prod   = {{LW{1'b0}}, cfg_data_i[wto_pkg::START_PHASE_W-1:0]} *
                        {{wto_pkg::START_PHASE_W{1'b0}}, len_q};
  assign start_frac_w = {start_prod[wto_pkg::START_PHASE_W-1:0], {F{1'b0}}};
  assign start_phase  = {start_prod[wto_pkg::START_PHASE_W+AW-1:wto_pkg::START_PHASE_W],
                         start_frac_w[wto_pkg::START_PHASE_W+F-1:wto_pkg::START_PHASE_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LW'(LEN_RST);
      lor_q    <= wto_pkg::LENGTH_OVER_RATE_RST;
      interp_q <= wto_pkg::INTERPOLATE_RST;
    end else if (cfg_we_i) begin
      unique case (wto_pkg::cfg_reg_e'(cfg_index_i))
        wto_pkg::CFG_TABLE_LENGTH:     len_q    <= len_d;
        wto_pkg::CFG_LENGTH_OVER_RATE: lor_q    <= cfg_data_i;
        wto_pkg::CFG_INTERPOLATE:      interp_q <= cfg_data_i[0];
        wto_pkg::CFG_START_PHASE:      ;
        default:                       ;
      endcase
    end
  end

  // A length change folds the phase index; a start phase write cancels that.
  assign mod_ctl.start = cfg_len_we;
  assign mod_ctl.abort = cfg_start_we;

  wto_phase_mod #(
    .AW (AW),
    .LW (LW)
  ) u_phase_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mod_ctl),
    .len_i  (len_d),
    .idx_i  (phase_q[PHW-1:F]),
    .busy_o (mod_busy),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // ---------------------------------------------------------------------
  // Stage A: input register, increment multiply
  // ---------------------------------------------------------------------
  logic        a_neg;
  logic [31:0] a_fmag;

  assign a_neg  = a_freq_q[wto_pkg::FREQ_W-1];
  assign a_fmag = a_neg ? (~a_freq_q + 32'd1) : a_freq_q;

  // ---------------------------------------------------------------------
  // Stage B: align and saturate the increment below the table span
  // ---------------------------------------------------------------------
  logic [63:0]    b_mag_full;
  logic [SPW-1:0] span_m1;
  logic [PHW-1:0] b_mag;

  assign b_mag_full = b_prod_q >> SH;
  assign span_m1    = span - SPW'(1);
  assign b_mag      = (b_mag_full >= 64'(span)) ? span_m1[PHW-1:0] : b_mag_full[PHW-1:0];

  // ---------------------------------------------------------------------
  // Stage C: table access and phase advance
  // ---------------------------------------------------------------------
  logic [AW-1:0]                        c_idx, c_nxt;
  logic [LW-1:0]                        c_nxt_w;
  logic [F-1:0]                         c_frac;
  logic [PHW:0]                         ph_ext, mg_ext, ph_sum, ph_up, ph_dn;
  logic [AW+wto_pkg::TABLE_INDEX_W-1:0] c_addr_w;
  logic                                 c_in_range;
  logic [SB+wto_pkg::TABLE_WORD_W-1:0]  c_word_w;

  assign c_idx   = phase_q[PHW-1:F];
  assign c_nxt_w = {1'b0, c_idx} + LW'(1);
  assign c_nxt   = (c_nxt_w >= len_q) ? '0 : c_nxt_w[AW-1:0];
  assign c_frac  = interp_q ? phase_q[F-1:0] : '0;

  // Wrap the advanced phase back into [0, span).
  always_comb begin
    ph_ext = {1'b0, phase_q};
    mg_ext = {1'b0, c_mag_q};
    ph_sum = ph_ext + mg_ext;
    ph_up  = (ph_sum >= span) ? (ph_sum - span) : ph_sum;
    ph_dn  = (phase_q >= c_mag_q) ? (ph_ext - mg_ext) : (ph_ext + span - mg_ext);
  end

  assign c_addr_w   = {{AW{1'b0}}, c_index_q};
  assign c_in_range = {20'd0, c_index_q} < 32'(TABLE_DEPTH);
  assign c_word_w   = {{SB{1'b0}}, c_word_q};

  // Phase register: start phase write, then reduction result, then tick advance.
  always_comb begin
    phase_d = phase_q;
    if (cfg_start_we) begin
      phase_d = start_phase;
    end else if (mod_done) begin
      phase_d = {mod_rem, phase_q[F-1:0]};
    end else if (c_tick_fire) begin
      phase_d = c_neg_q ? ph_dn[PHW-1:0] : ph_up[PHW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_write_fire && c_in_range) begin
      mem_q[c_addr_w[AW-1:0]] <= c_word_w[SB-1:0];
    end
    if (free_d) begin
      d_a_q    <= mem_q[c_idx];
      d_b_q    <= mem_q[c_nxt];
      d_frac_q <= c_frac;
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: difference times fraction
  // ---------------------------------------------------------------------
  logic signed [SB:0]   d_diff;
  logic signed [F:0]    d_frac_s;
  logic signed [PW-1:0] d_prod;

  assign d_diff   = $signed({d_b_q[SB-1], d_b_q}) - $signed({d_a_q[SB-1], d_a_q});
  assign d_frac_s = $signed({1'b0, d_frac_q});
  assign d_prod   = d_diff * d_frac_s;

  // ---------------------------------------------------------------------
  // Stage E: floor of the scaled difference added to the lower entry
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] e_shf, e_a_ext, e_sum;

  assign e_shf   = e_prod_q >>> F;
  assign e_a_ext = $signed({{(F+2){e_a_q[SB-1]}}, e_a_q});
  assign e_sum   = e_a_ext + e_shf;

  // ---------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
      phase_q <= '0;
    end else begin
      if (free_a) a_vld_q <= s_fire;
      if (free_b) b_vld_q <= a_vld_q;
      if (free_c) c_vld_q <= b_vld_q;
      if (free_d) d_vld_q <= c_vld_q && c_tick_q;
      if (free_e) e_vld_q <= d_vld_q;
      if (free_o) o_vld_q <= e_vld_q;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_tick_q  <= (wto_pkg::act_e'(s_axis_tuser) == wto_pkg::ACT_TICK);
      a_index_q <= s_axis_tdata[11:0];
      a_word_q  <= s_axis_tdata[27:12];
      a_freq_q  <= s_axis_tdata[59:28];
    end
    if (free_b) begin
      b_tick_q  <= a_tick_q;
      b_index_q <= a_index_q;
      b_word_q  <= a_word_q;
      b_neg_q   <= a_neg;
      b_prod_q  <= {32'd0, a_fmag} * {32'd0, lor_q};
    end
    if (free_c) begin
      c_tick_q  <= b_tick_q;
      c_index_q <= b_index_q;
      c_word_q  <= b_word_q;
      c_neg_q   <= b_neg_q;
      c_mag_q   <= b_mag;
    end
    if (free_e) begin
      e_a_q    <= d_a_q;
      e_prod_q <= d_prod;
    end
    if (free_o) begin
      o_sample_q <= e_sum[SB-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // No beat is taken while the phase is being folded into a new length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_busy |-> !s_axis_tready)
    else $error("input beat accepted during phase reduction");

  // Outside a reduction the phase stays inside the table span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mod_busy |-> ({1'b0, phase_q} < span))
    else $error("phase outside table span");

  // The saturated increment never reaches a whole table span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q && c_tick_q |-> ({1'b0, c_mag_q} < span))
    else $error("phase increment not saturated");

  // Every tick that leaves the phase stage yields a table read in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_tick_fire |=> d_vld_q)
    else $error("tick lost after phase stage");

endmodule
